FILE: rtl/ept_pw_pkg.sv
// Shared types, codes and helpers for the EPT page walker.
package ept_pw_pkg;

    // Default depth of the queue between front and back
    localparam int QueueDepth = 2;

    // Classes of work word handed from front to back
    localparam logic [1:0] CLS_START    = 2'd0;
    localparam logic [1:0] CLS_RANGE    = 2'd1;
    localparam logic [1:0] CLS_NO_ROOT  = 2'd2;
    localparam logic [1:0] CLS_DATA     = 2'd3;

    // Result kinds
    localparam logic KIND_REQ   = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_LEAF      = 3'd0;
    localparam logic [2:0] ST_UNMAPPED  = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_NO_ROOT   = 3'd3;
    localparam logic [2:0] ST_READ_FAIL = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;

    // Table levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // Classified input word
    typedef struct packed {
        logic [1:0]  cls;
        logic        read_ok;
        logic [63:0] data;     // guest address for a start, entry for read data
    } t_work;

    // One result word
    typedef struct packed {
        logic        kind;
        logic [51:0] address;
        logic [2:0]  status;
        logic [1:0]  leaf_level;
        logic        large_page;
        logic        readable;
        logic        writable;
        logic        executable;
        logic [2:0]  memory_type;
        logic        ignore_pat;
        logic        suppress_ve;
    } t_result;

    // Pick the nine index bits of a level out of the 36-bit page number
    function automatic logic [8:0] slot_index(input logic [35:0] page,
                                              input logic [1:0]  level);
        logic [8:0] idx;
        case (level)
            LVL_PML4: idx = page[35:27];
            LVL_PDPT: idx = page[26:18];
            LVL_PD:   idx = page[17:9];
            LVL_PT:   idx = page[8:0];
            default:  idx = page[8:0];
        endcase
        return idx;
    endfunction

endpackage

FILE: rtl/ept_pw_front.sv
// Front end: accept input words, classify them and queue them for the back end.
module ept_pw_front #(
    parameter int DEPTH = ept_pw_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [63:0]          i_guest_address,
    input  logic [63:0]          i_entry_data,
    input  logic                 i_read_ok,
    input  logic                 i_root_zero,
    output logic                 o_word_valid,
    input  logic                 i_word_ready,
    output ept_pw_pkg::t_work    o_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ept_pw_pkg::t_work r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    ept_pw_pkg::t_work w_class;
    logic              w_push, w_pop;

    // Classify the incoming word
    always_comb begin
        w_class.read_ok = i_read_ok;
        if (i_operation) begin
            w_class.cls  = ept_pw_pkg::CLS_DATA;
            w_class.data = i_entry_data;
        end else begin
            w_class.data = i_guest_address;
            if (i_guest_address[63:48] != 16'd0) begin
                w_class.cls = ept_pw_pkg::CLS_RANGE;
            end else if (i_root_zero) begin
                w_class.cls = ept_pw_pkg::CLS_NO_ROOT;
            end else begin
                w_class.cls = ept_pw_pkg::CLS_START;
            end
        end
    end

    // Queue handshake
    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign o_word_valid = (r_count != '0);
    assign o_word       = r_mem[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_word_valid && i_word_ready;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    // Fill count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

endmodule

FILE: rtl/ept_pw_back.sv
// Back end: walk state, next-read and final-result generation, output register.
module ept_pw_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_word_valid,
    output logic                  o_word_ready,
    input  ept_pw_pkg::t_work     i_word,
    input  logic [39:0]           i_root_frame,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ept_pw_pkg::t_result   o_result
);

    logic                r_pending, n_pending;
    logic [1:0]          r_level, n_level;
    logic [35:0]         r_page, n_page;
    logic                r_out_valid;
    ept_pw_pkg::t_result r_out, n_out;
    logic                n_has;
    logic                w_take;
    logic [1:0]          w_next_level;
    logic [63:0]         w_entry;

    assign o_word_ready = !r_out_valid || i_ready;
    assign w_take       = i_word_valid && o_word_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;
    assign w_entry      = i_word.data;
    assign w_next_level = r_level + 2'd1;

    // Work out the result and the next walk state for the word at the head
    always_comb begin
        n_pending = r_pending;
        n_level   = r_level;
        n_page    = r_page;
        n_has     = 1'b1;
        n_out     = '0;
        n_out.kind = ept_pw_pkg::KIND_FINAL;
        if (i_word.cls != ept_pw_pkg::CLS_DATA) begin
            if (r_pending) begin
                n_out.status = ept_pw_pkg::ST_BUSY;
            end else if (i_word.cls == ept_pw_pkg::CLS_RANGE) begin
                n_out.status = ept_pw_pkg::ST_RANGE;
            end else if (i_word.cls == ept_pw_pkg::CLS_NO_ROOT) begin
                n_out.status = ept_pw_pkg::ST_NO_ROOT;
            end else begin
                // start the walk at the root table
                n_pending        = 1'b1;
                n_level          = ept_pw_pkg::LVL_PML4;
                n_page           = w_entry[47:12];
                n_out.kind       = ept_pw_pkg::KIND_REQ;
                n_out.address    = {i_root_frame, w_entry[47:39], 3'b000};
                n_out.leaf_level = ept_pw_pkg::LVL_PML4;
            end
        end else if (!r_pending) begin
            // drop stray read data
            n_has = 1'b0;
        end else if (!i_word.read_ok) begin
            n_pending        = 1'b0;
            n_out.status     = ept_pw_pkg::ST_READ_FAIL;
            n_out.leaf_level = r_level;
        end else if (w_entry == 64'd0) begin
            n_pending        = 1'b0;
            n_out.status     = ept_pw_pkg::ST_UNMAPPED;
            n_out.leaf_level = r_level;
        end else if (r_level == ept_pw_pkg::LVL_PT || (w_entry[7] &&
                     (r_level == ept_pw_pkg::LVL_PDPT || r_level == ept_pw_pkg::LVL_PD))) begin
            // leaf: mask the frame to the page size of this level
            n_pending         = 1'b0;
            n_out.status      = ept_pw_pkg::ST_LEAF;
            n_out.leaf_level  = r_level;
            n_out.readable    = w_entry[0];
            n_out.writable    = w_entry[1];
            n_out.executable  = w_entry[2];
            n_out.memory_type = w_entry[5:3];
            n_out.ignore_pat  = w_entry[6];
            n_out.suppress_ve = w_entry[63];
            case (r_level)
                ept_pw_pkg::LVL_PDPT: begin
                    n_out.large_page = 1'b1;
                    n_out.address    = {w_entry[51:30], 30'd0};
                end
                ept_pw_pkg::LVL_PD: begin
                    n_out.large_page = 1'b1;
                    n_out.address    = {w_entry[51:21], 21'd0};
                end
                default: begin
                    n_out.large_page = 1'b0;
                    n_out.address    = {w_entry[51:12], 12'd0};
                end
            endcase
        end else begin
            // descend one level and ask for the next entry
            n_level          = w_next_level;
            n_out.kind       = ept_pw_pkg::KIND_REQ;
            n_out.leaf_level = w_next_level;
            n_out.address    = {w_entry[51:12],
                                ept_pw_pkg::slot_index(r_page, w_next_level), 3'b000};
        end
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_level   <= '0;
            r_page    <= '0;
        end else if (w_take) begin
            r_pending <= n_pending;
            r_level   <= n_level;
            r_page    <= n_page;
        end
    end

    // Output register: load on take, drop once taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= n_has;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    // A read request waiting at the output belongs to the live walk
    a_req_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == ept_pw_pkg::KIND_REQ) |-> r_pending)
        else $error("read request shown with no walk pending");

    // The level of a waiting request is the level the walk is at
    a_req_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == ept_pw_pkg::KIND_REQ) |-> (r_out.leaf_level == r_level))
        else $error("request level differs from walk level");

    // Large pages only end a walk at PDPT or PD
    a_large_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.large_page) |->
        (r_out.leaf_level == ept_pw_pkg::LVL_PDPT || r_out.leaf_level == ept_pw_pkg::LVL_PD))
        else $error("large page at wrong level");

endmodule

FILE: rtl/ept_four_level_page_walker.sv
// Top level of the four-level EPT page walker: root pointer register, front and back ends.
//
//  Channel   Direction  Handshake               Word
//  input     in         i_valid / o_ready       operation, guest_address, entry_data, read_ok
//  result    out        o_valid / i_ready       kind, address, status, level, leaf attributes
//  config    in         i_cfg_wr_en             i_cfg_wr_data (EPT pointer)
//
//  One word per cycle sustained while the result side does not stall; an accepted word
//  is written into the queue at the accepting edge, then evaluated by the back end into
//  the output register.
//  Reset (synchronous, active low) clears the queue, the walk state, the output valid
//  and the root pointer. The queue holds QUEUE_DEPTH words, so input keeps flowing until
//  the queue is full while the result side stalls; the back end holds its word until the
//  output register frees up.
module ept_four_level_page_walker #(
    parameter int QUEUE_DEPTH = ept_pw_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [63:0] i_guest_address,
    input  logic [63:0] i_entry_data,
    input  logic        i_read_ok,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [51:0] o_address,
    output logic [2:0]  o_status,
    output logic [1:0]  o_leaf_level,
    output logic        o_large_page,
    output logic        o_readable,
    output logic        o_writable,
    output logic        o_executable,
    output logic [2:0]  o_memory_type,
    output logic        o_ignore_pat,
    output logic        o_suppress_ve
);

    logic [63:0]         r_root;
    logic                w_word_valid, w_word_ready;
    ept_pw_pkg::t_work   w_word;
    ept_pw_pkg::t_result w_result;

    // Hold the EPT pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_wr_en) begin
            r_root <= i_cfg_wr_data;
        end
    end

    ept_pw_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_guest_address (i_guest_address),
        .i_entry_data    (i_entry_data),
        .i_read_ok       (i_read_ok),
        .i_root_zero     (r_root == 64'd0),
        .o_word_valid    (w_word_valid),
        .i_word_ready    (w_word_ready),
        .o_word          (w_word)
    );

    ept_pw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (w_word_valid),
        .o_word_ready (w_word_ready),
        .i_word       (w_word),
        .i_root_frame (r_root[51:12]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (w_result)
    );

    // Unpack the result word onto the ports
    assign o_kind        = w_result.kind;
    assign o_address     = w_result.address;
    assign o_status      = w_result.status;
    assign o_leaf_level  = w_result.leaf_level;
    assign o_large_page  = w_result.large_page;
    assign o_readable    = w_result.readable;
    assign o_writable    = w_result.writable;
    assign o_executable  = w_result.executable;
    assign o_memory_type = w_result.memory_type;
    assign o_ignore_pat  = w_result.ignore_pat;
    assign o_suppress_ve = w_result.suppress_ve;

endmodule

FILE: dv/ept_four_level_page_walker_test.sv
// Self-checking testbench for the four-level EPT page walker: directed walks, then random walks.
module ept_four_level_page_walker_test;

    // Operation codes of an input word
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_READ_DATA = 1'b1;

    // First guest address beyond the 48-bit space
    localparam logic [63:0] ADDR_LIMIT = 64'h0001_0000_0000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [63:0] i_cfg_wr_data = 64'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic [63:0] i_guest_address = 64'd0;
    logic [63:0] i_entry_data = 64'd0;
    logic        i_read_ok = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [51:0] o_address;
    logic [2:0]  o_status;
    logic [1:0]  o_leaf_level;
    logic        o_large_page;
    logic        o_readable;
    logic        o_writable;
    logic        o_executable;
    logic [2:0]  o_memory_type;
    logic        o_ignore_pat;
    logic        o_suppress_ve;

    // Walker state as the testbench sees it
    logic [63:0] root_ptr = 64'd0;
    logic        walk_busy = 1'b0;
    logic [1:0]  walk_level = ept_pw_pkg::LVL_PML4;
    logic [35:0] page_num = 36'd0;

    ept_pw_pkg::t_result awaited_words[$];
    ept_pw_pkg::t_result head_word;
    int      fail_count = 0;
    int      outcomes_given = 0;
    int      ready_hold = 0;
    int      stall_draw;
    bit      pace_on = 1'b1;
    bit      valid_up = 1'b0;

    ept_four_level_page_walker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_guest_address (i_guest_address),
        .i_entry_data    (i_entry_data),
        .i_read_ok       (i_read_ok),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_address       (o_address),
        .o_status        (o_status),
        .o_leaf_level    (o_leaf_level),
        .o_large_page    (o_large_page),
        .o_readable      (o_readable),
        .o_writable      (o_writable),
        .o_executable    (o_executable),
        .o_memory_type   (o_memory_type),
        .o_ignore_pat    (o_ignore_pat),
        .o_suppress_ve   (o_suppress_ve)
    );

    always #4 i_clk = ~i_clk;

    // Generous ceiling on the whole run
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    // Address of the entry for the current level inside the given table
    function automatic logic [51:0] entry_address(input logic [63:0] table_ptr);
        logic [8:0] slot;
        slot = 9'(page_num >> (27 - 9 * walk_level));
        return {table_ptr[51:12], slot, 3'b000};
    endfunction

    // Advance the walk by one word; return 1 when the word yields a result
    function automatic bit walk_outcome(input logic op, input logic [63:0] gpa,
                                        input logic [63:0] entry, input logic ok,
                                        output ept_pw_pkg::t_result res);
        bit leaf;
        res  = '0;
        leaf = 1'b0;
        res.kind = ept_pw_pkg::KIND_FINAL;
        if (op == OP_TRANSLATE) begin
            if (walk_busy) begin
                res.status = ept_pw_pkg::ST_BUSY;
            end else if (gpa >= ADDR_LIMIT) begin
                res.status = ept_pw_pkg::ST_RANGE;
            end else if (root_ptr == 64'd0) begin
                res.status = ept_pw_pkg::ST_NO_ROOT;
            end else begin
                page_num   = gpa[47:12];
                walk_level = ept_pw_pkg::LVL_PML4;
                walk_busy  = 1'b1;
                res.kind       = ept_pw_pkg::KIND_REQ;
                res.address    = entry_address(root_ptr);
                res.leaf_level = walk_level;
            end
            return 1'b1;
        end
        // Drop read data that arrives with no walk open
        if (!walk_busy) begin
            return 1'b0;
        end
        res.leaf_level = walk_level;
        if (!ok) begin
            walk_busy  = 1'b0;
            res.status = ept_pw_pkg::ST_READ_FAIL;
        end else if (entry == 64'd0) begin
            walk_busy  = 1'b0;
            res.status = ept_pw_pkg::ST_UNMAPPED;
        end else if (entry[7] && (walk_level == ept_pw_pkg::LVL_PDPT ||
                                  walk_level == ept_pw_pkg::LVL_PD)) begin
            leaf = 1'b1;
            res.large_page = 1'b1;
            res.address = (walk_level == ept_pw_pkg::LVL_PDPT) ? {entry[51:30], 30'd0}
                                                               : {entry[51:21], 21'd0};
        end else if (walk_level == ept_pw_pkg::LVL_PT) begin
            leaf = 1'b1;
            res.address = {entry[51:12], 12'd0};
        end else begin
            walk_level     = walk_level + 2'd1;
            res.kind       = ept_pw_pkg::KIND_REQ;
            res.address    = entry_address(entry);
            res.leaf_level = walk_level;
        end
        // Copy the leaf attributes and close the walk
        if (leaf) begin
            walk_busy       = 1'b0;
            res.status      = ept_pw_pkg::ST_LEAF;
            res.readable    = entry[0];
            res.writable    = entry[1];
            res.executable  = entry[2];
            res.memory_type = entry[5:3];
            res.ignore_pat  = entry[6];
            res.suppress_ve = entry[63];
        end
        return 1'b1;
    endfunction

    // Take result words, check them against the oldest awaited word, pace ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch("result word with none awaited", 64'(o_address), 64'd0);
                end else begin
                    head_word = awaited_words.pop_front();
                    compare_field("kind", 64'(o_kind), 64'(head_word.kind));
                    compare_field("address", 64'(o_address), 64'(head_word.address));
                    compare_field("status", 64'(o_status), 64'(head_word.status));
                    compare_field("leaf_level", 64'(o_leaf_level),
                                  64'(head_word.leaf_level));
                    compare_field("large_page", 64'(o_large_page),
                                  64'(head_word.large_page));
                    compare_field("readable", 64'(o_readable), 64'(head_word.readable));
                    compare_field("writable", 64'(o_writable), 64'(head_word.writable));
                    compare_field("executable", 64'(o_executable),
                                  64'(head_word.executable));
                    compare_field("memory_type", 64'(o_memory_type),
                                  64'(head_word.memory_type));
                    compare_field("ignore_pat", 64'(o_ignore_pat),
                                  64'(head_word.ignore_pat));
                    compare_field("suppress_ve", 64'(o_suppress_ve),
                                  64'(head_word.suppress_ve));
                end
                stall_draw = pace_on ? $urandom_range(0, 13) : 0;
                if (stall_draw != 0) begin
                    i_ready    <= 1'b0;
                    ready_hold <= stall_draw;
                end
            end else if (!i_ready) begin
                if (ready_hold <= 1) begin
                    i_ready <= 1'b1;
                end else begin
                    ready_hold <= ready_hold - 1;
                end
            end
        end
    end

    // Offer one word, hold it until accepted, then log what it should yield
    task automatic send_word(input logic op, input logic [63:0] gpa,
                             input logic [63:0] entry, input logic ok);
        int                  gap;
        ept_pw_pkg::t_result res;
        gap = pace_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            if (valid_up) begin
                i_valid <= 1'b0;
            end
            valid_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_guest_address <= gpa;
        i_entry_data    <= entry;
        i_read_ok       <= ok;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (walk_outcome(op, gpa, entry, ok, res)) begin
            awaited_words.push_back(res);
            outcomes_given++;
        end
    endtask

    // Unused fields of a word carry random bits
    task automatic send_translate(input logic [63:0] gpa);
        send_word(OP_TRANSLATE, gpa, {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic send_entry(input logic [63:0] entry, input logic ok);
        send_word(OP_READ_DATA, {$urandom, $urandom}, entry, ok);
    endtask

    // Hold off input until every awaited word is back and the pipe is empty
    task automatic drain_walker();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
            @(posedge i_clk);
        end
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [63:0] value);
        drain_walker();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        root_ptr = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Rejections with no root loaded, and read data with no walk open
    task automatic test_rejects();
        send_translate(64'd0);
        send_translate(ADDR_LIMIT);
        send_translate(64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_translate(ADDR_LIMIT - 64'd1);
    endtask

    // Hand-picked walks: every level, large pages, busy, unmapped, failed read
    task automatic test_directed_walks();
        write_root(64'hFFFF_FFFF_FFFF_FFFF);
        send_translate(ADDR_LIMIT - 64'd1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        write_root(64'h0000_0000_0000_1FFF);
        send_translate(64'd0);
        send_entry(64'h0000_0000_0000_1080, 1'b1);
        send_entry(64'h0000_0000_0000_2000, 1'b1);
        send_entry(64'h0000_0000_0020_00FF, 1'b1);

        send_translate(64'h0000_1234_5678_9ABC);
        send_entry(64'h0000_0000_0000_3003, 1'b1);
        send_entry(64'h0000_0000_0000_4000, 1'b1);
        send_entry(64'h0000_0000_0000_5000, 1'b1);
        send_translate(64'h0000_0000_0000_1000);
        send_entry(64'h8000_0000_DEAD_B0FF, 1'b1);

        send_translate(64'h0000_8000_0000_0000);
        send_entry(64'd0, 1'b1);
        send_translate(64'h0000_7FFF_FFFF_F000);
        send_entry(64'h0000_0000_0000_6007, 1'b1);
        send_entry(64'h0000_0000_0000_7007, 1'b0);
        send_translate(64'h0000_0000_4020_1000);
        send_entry(64'h0000_0000_0000_8007, 1'b1);
        send_entry(64'h0000_0000_0000_9007, 1'b1);
        send_entry(64'h0000_0000_0000_A007, 1'b1);
        send_entry(64'd0, 1'b1);
    endtask

    function automatic logic [63:0] random_entry();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return 64'd0;
        end else if (pick == 1) begin
            return 64'hFFFF_FFFF_FFFF_FFFF;
        end
        return {$urandom, $urandom};
    endfunction

    // Mostly whole walks with random content, the rest noise and broken walks
    task automatic random_walks(input int target);
        int mark;
        int pick;
        int steps;
        mark = outcomes_given;
        while (outcomes_given - mark < target) begin
            if (((outcomes_given - mark) % 40) == 0) begin
                pace_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_entry(random_entry(), 1'($urandom));
            end else if (pick == 1) begin
                send_translate({$urandom, $urandom} | ADDR_LIMIT);
            end else begin
                send_translate({$urandom, $urandom} & (ADDR_LIMIT - 64'd1));
                steps = 0;
                while (walk_busy && steps < 8) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send_translate({$urandom, $urandom});
                    end else begin
                        send_entry(random_entry(), $urandom_range(0, 15) != 0);
                    end
                    steps++;
                end
            end
        end
    endtask

    // Random phases over several root settings, extremes included
    task automatic test_random_phases();
        write_root(64'd0);
        random_walks(60);
        write_root(64'hFFFF_FFFF_FFFF_FFFF);
        random_walks(220);
        write_root(64'h0000_0000_0000_1000);
        random_walks(220);
        drain_walker();
        random_walks(100);
        write_root(64'h0000_0000_0000_0FFF);
        random_walks(150);
        write_root({$urandom, $urandom});
        random_walks(250);
        write_root({$urandom, $urandom} & 64'h000F_FFFF_FFFF_F000);
        random_walks(250);
        pace_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_rejects();
        test_directed_walks();
        test_random_phases();
        drain_walker();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
